// File: rtl/gjr_pkg.sv
// Shared types and constants for the GJR-GARCH variance recursion core.
// Used by gjr_mul, gjr_sqrt and gjr_garch_variance_recursion_core.
// No dependencies.
package gjr_pkg;

    // Lag depth of the variance, squared residual and negative-shock squared residual history.
    localparam int MAX_ORDER = 2;
    localparam int LAG_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    // Q16.16 data word and derived widths.
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int QPROD_W   = PROD_W - FRAC_W;
    localparam int ACC_W     = QPROD_W + 4;

    // Square root: radicand is h shifted up by the fraction width.
    localparam int SQRT_IN_W = DATA_W + FRAC_W;
    localparam int ROOT_W    = SQRT_IN_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int SQRT_REM_W = ROOT_W + 2;

    // Stream widths.
    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 72;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_2  = 3'd6;

    // Request kinds carried in s_tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_W,
        ST_SAT,
        ST_ROOT,
        ST_RES,
        ST_RES_W,
        ST_SQ,
        ST_SQ_W
    } state_t;

    // Which coefficient/history pair the multiply-accumulate pass is on.
    typedef enum logic [1:0] {
        TERM_ALPHA,
        TERM_GAMMA,
        TERM_BETA
    } term_t;

endpackage

// File: rtl/gjr_mul.sv
// Shared signed Q16.16 multiplier with registered product and round-half-up.
// Depends on gjr_pkg.
module gjr_mul (
    input  logic                                aclk,
    input  logic signed [gjr_pkg::DATA_W-1:0]   a,
    input  logic signed [gjr_pkg::DATA_W-1:0]   b,
    output logic signed [gjr_pkg::QPROD_W-1:0]  q
);
    import gjr_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_rnd;

    // Full product, registered before any further arithmetic.
    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    // Add one half LSB and drop the fraction bits (floor shift).
    assign prod_rnd = prod_reg + PROD_W'(64'sd1 <<< (FRAC_W - 1));
    assign q        = prod_rnd[PROD_W-1:FRAC_W];

endmodule

// File: rtl/gjr_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on gjr_pkg.
module gjr_sqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [gjr_pkg::SQRT_IN_W-1:0]     x,
    output logic                              done,
    output logic [gjr_pkg::ROOT_W-1:0]        root
);
    import gjr_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [ROOT_CNT_W-1:0]   cnt_reg;
    logic [SQRT_IN_W-1:0]    rad_reg;
    logic [SQRT_REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]       root_reg;

    logic [SQRT_REM_W+1:0]   rem_sh;
    logic [SQRT_REM_W+1:0]   trial;
    logic                    fits;
    logic [SQRT_REM_W+1:0]   rem_sub;

    // One restoring step: bring down two radicand bits, try root*4+1.
    always_comb begin
        rem_sh  = {rem_reg, rad_reg[SQRT_IN_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        fits    = (rem_sh >= trial);
        rem_sub = rem_sh - trial;
    end

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ROOT_CNT_W'(ROOT_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, root and radicand shift.
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[SQRT_IN_W-3:0], 2'b00};
            rem_reg  <= fits ? rem_sub[SQRT_REM_W-1:0] : rem_sh[SQRT_REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/gjr_garch_variance_recursion_core.sv
// Top level of the GJR-GARCH variance recursion core: sequencer, registers,
// history and output stage. Depends on gjr_pkg, gjr_mul and gjr_sqrt.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  tdata h_in,e_in,nres_in,z,vx,neg; tuser operation
//  m_       out        m_tvalid/m_tready  tdata h_out,res_out,flag
//  cfg_     in         cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// A load request leaves the block ready again at once.
// A step request runs from the idle state that accepts it through the
// multiply-accumulate passes and a drain of the multiplier, saturation,
// the bit-serial square root, and the residual and its square.
// aresetn is synchronous; it clears coefficients, history and the output valid.
// A result waiting on m_tready holds the last step until the output is free.
module gjr_garch_variance_recursion_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gjr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gjr_pkg::DATA_W-1:0]         cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // h_in[31:0], e_in[63:32], nres_in[95:64], z[127:96], vx[159:128],
    // neg[160], zero fill [167:161]
    input  logic [gjr_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation[0]
    input  logic [gjr_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // h_out[31:0], res_out[63:32], flag[64], zero fill [71:65]
    output logic [gjr_pkg::M_TDATA_W-1:0]      m_tdata
);
    import gjr_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } sat_t;

    // Saturate a wide signed value to the 32-bit signed range.
    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t r;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = ACC_W'(-64'sd2147483648);
        if (v > hi) begin
            r.val = {1'b0, {(DATA_W-1){1'b1}}};
            r.ovf = 1'b1;
        end else if (v < lo) begin
            r.val = {1'b1, {(DATA_W-1){1'b0}}};
            r.ovf = 1'b1;
        end else begin
            r.val = v[DATA_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // Input field unpacking.
    logic                      in_op;
    logic signed [DATA_W-1:0]  in_h;
    logic signed [DATA_W-1:0]  in_e;
    logic signed [DATA_W-1:0]  in_n;
    logic signed [DATA_W-1:0]  in_z;
    logic signed [DATA_W-1:0]  in_vx;
    logic                      in_neg;

    assign in_op  = s_tuser[0];
    assign in_h   = s_tdata[31:0];
    assign in_e   = s_tdata[63:32];
    assign in_n   = s_tdata[95:64];
    assign in_z   = s_tdata[127:96];
    assign in_vx  = s_tdata[159:128];
    assign in_neg = s_tdata[160];

    // Control and state registers.
    state_t                    state_reg, state_next;
    term_t                     term_reg;
    logic [LAG_W-1:0]          lag_reg;
    logic                      prod_vld_reg;
    logic                      m_tvalid_reg;

    // Coefficients and history.
    logic signed [DATA_W-1:0]  omega_reg;
    logic signed [DATA_W-1:0]  alpha_reg [MAX_ORDER];
    logic signed [DATA_W-1:0]  gamma_reg [MAX_ORDER];
    logic signed [DATA_W-1:0]  beta_reg  [MAX_ORDER];
    logic signed [DATA_W-1:0]  var_hist_reg   [MAX_ORDER];
    logic signed [DATA_W-1:0]  sqres_hist_reg [MAX_ORDER];
    logic signed [DATA_W-1:0]  negsq_hist_reg [MAX_ORDER];

    // Per-step datapath registers.
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DATA_W-1:0]  h_reg;
    logic signed [DATA_W-1:0]  res_reg;
    logic signed [DATA_W-1:0]  z_reg;
    logic                      neg_reg;
    logic                      flag_reg;
    logic [DATA_W-1:0]         m_h_reg;
    logic [DATA_W-1:0]         m_res_reg;
    logic                      m_flag_reg;

    // Sequencer outputs and datapath nets.
    logic                      accept;
    logic                      accept_load;
    logic                      accept_step;
    logic                      mac_last;
    logic                      out_free;
    logic                      sq_fin;
    logic                      root_start;
    logic                      root_done;
    logic [ROOT_W-1:0]         root;
    logic [SQRT_IN_W-1:0]      root_x;
    logic signed [DATA_W-1:0]  mul_a;
    logic signed [DATA_W-1:0]  mul_b;
    logic signed [QPROD_W-1:0] mul_q;
    logic signed [ACC_W-1:0]   mul_q_ext;
    sat_t                      h_sat;
    sat_t                      q_sat;
    logic                      h_neg;
    logic                      push_en;
    logic signed [DATA_W-1:0]  push_h;
    logic signed [DATA_W-1:0]  push_e;
    logic signed [DATA_W-1:0]  push_n;

    // Shared arithmetic units.
    gjr_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .q    (mul_q)
    );

    gjr_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .x       (root_x),
        .done    (root_done),
        .root    (root)
    );

    assign mul_q_ext = ACC_W'(mul_q);
    assign h_sat     = sat32(acc_reg);
    assign q_sat     = sat32(mul_q_ext);
    assign h_neg     = h_sat.val[DATA_W-1];
    assign root_x    = h_neg ? '0 : {h_sat.val, {FRAC_W{1'b0}}};
    assign mac_last  = (term_reg == TERM_BETA) && (lag_reg == LAG_W'(MAX_ORDER - 1));
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && in_op == OP_STEP) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (mac_last) begin
                    state_next = ST_MAC_W;
                end
            end
            ST_MAC_W: state_next = ST_SAT;
            ST_SAT:   state_next = ST_ROOT;
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_RES;
                end
            end
            ST_RES:   state_next = ST_RES_W;
            ST_RES_W: state_next = ST_SQ;
            ST_SQ:    state_next = ST_SQ_W;
            ST_SQ_W: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, root start and multiplier operands.
    always_comb begin
        s_tready   = 1'b0;
        root_start = 1'b0;
        sq_fin     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_MAC: begin
                case (term_reg)
                    TERM_ALPHA: begin
                        mul_a = alpha_reg[lag_reg];
                        mul_b = sqres_hist_reg[lag_reg];
                    end
                    TERM_GAMMA: begin
                        mul_a = gamma_reg[lag_reg];
                        mul_b = negsq_hist_reg[lag_reg];
                    end
                    TERM_BETA: begin
                        mul_a = beta_reg[lag_reg];
                        mul_b = var_hist_reg[lag_reg];
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_SAT: root_start = 1'b1;
            ST_RES: begin
                mul_a = DATA_W'(root);
                mul_b = z_reg;
            end
            ST_SQ: begin
                mul_a = res_reg;
                mul_b = res_reg;
            end
            ST_SQ_W: begin
                mul_a  = res_reg;
                mul_b  = res_reg;
                sq_fin = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept      = s_tvalid && s_tready;
    assign accept_load = accept && (in_op == OP_LOAD);
    assign accept_step = accept && (in_op == OP_STEP);

    // History push: presample values on load, new values at the end of a step.
    always_comb begin
        push_en = accept_load || sq_fin;
        if (accept_load) begin
            push_h = in_h;
            push_e = in_e;
            push_n = in_n;
        end else begin
            push_h = h_reg;
            push_e = q_sat.val;
            push_n = neg_reg ? q_sat.val : '0;
        end
    end

    // Control state, configuration and history registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            term_reg     <= TERM_ALPHA;
            lag_reg      <= '0;
            prod_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            omega_reg    <= '0;
            for (int j = 0; j < MAX_ORDER; j++) begin
                alpha_reg[j]      <= '0;
                gamma_reg[j]      <= '0;
                beta_reg[j]       <= '0;
                var_hist_reg[j]   <= '0;
                sqres_hist_reg[j] <= '0;
                negsq_hist_reg[j] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            prod_vld_reg <= (state_reg == ST_MAC);

            // Walk the coefficient terms, lag by lag.
            if (accept_step) begin
                term_reg <= TERM_ALPHA;
                lag_reg  <= '0;
            end else if (state_reg == ST_MAC) begin
                case (term_reg)
                    TERM_ALPHA: term_reg <= TERM_GAMMA;
                    TERM_GAMMA: term_reg <= TERM_BETA;
                    default: begin
                        term_reg <= TERM_ALPHA;
                        lag_reg  <= lag_reg + 1'b1;
                    end
                endcase
            end

            // Output valid.
            if (sq_fin) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // Configuration writes.
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OMEGA:   omega_reg    <= cfg_wdata;
                    CFG_ALPHA_1: alpha_reg[0] <= cfg_wdata;
                    CFG_ALPHA_2: alpha_reg[1] <= cfg_wdata;
                    CFG_GAMMA_1: gamma_reg[0] <= cfg_wdata;
                    CFG_GAMMA_2: gamma_reg[1] <= cfg_wdata;
                    CFG_BETA_1:  beta_reg[0]  <= cfg_wdata;
                    CFG_BETA_2:  beta_reg[1]  <= cfg_wdata;
                    default: begin
                        omega_reg <= omega_reg;
                    end
                endcase
            end

            // Shift history by one lag.
            if (push_en) begin
                for (int j = MAX_ORDER - 1; j > 0; j--) begin
                    var_hist_reg[j]   <= var_hist_reg[j-1];
                    sqres_hist_reg[j] <= sqres_hist_reg[j-1];
                    negsq_hist_reg[j] <= negsq_hist_reg[j-1];
                end
                var_hist_reg[0]   <= push_h;
                sqres_hist_reg[0] <= push_e;
                negsq_hist_reg[0] <= push_n;
            end
        end
    end

    // Step datapath: accumulate, saturate, residual, squared residual.
    always_ff @(posedge aclk) begin
        if (accept_step) begin
            acc_reg  <= ACC_W'(in_h) + ACC_W'(omega_reg) + ACC_W'(in_vx);
            z_reg    <= in_z;
            neg_reg  <= in_neg;
            flag_reg <= 1'b0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + mul_q_ext;
        end else if (state_reg == ST_SAT) begin
            h_reg    <= h_sat.val;
            flag_reg <= h_sat.ovf || h_neg;
        end else if (state_reg == ST_RES_W) begin
            res_reg  <= q_sat.val;
            flag_reg <= flag_reg || q_sat.ovf;
        end
        if (sq_fin) begin
            m_h_reg    <= h_reg;
            m_res_reg  <= res_reg;
            m_flag_reg <= flag_reg || q_sat.ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_flag_reg, m_res_reg, m_h_reg};

    // A root result is only expected while the sequencer waits for it.
    a_root_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside its wait state");

    // A new result only appears at the end of a step.
    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_SQ_W)
        else $error("result raised outside the final step state");

    // An unflagged result never carries a negative variance.
    a_unflagged_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[64] |-> !m_tdata[31])
        else $error("negative variance without flag");

    // A negative variance gives a zero residual and sets the flag.
    a_neg_var_zero_res: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31] |-> m_tdata[63:32] == '0 && m_tdata[64])
        else $error("negative variance with nonzero residual");

endmodule
